@@ src/npgc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and tables for the great-circle nearest point search.
// Used by the CORDIC unit, the square root unit and the top level.
package npgc_pkg;

	// Table size and iteration counts.
	localparam int MAX_ENTRIES  = 64;
	localparam int CORDIC_STEPS = 24;
	localparam int SQRT_STEPS   = 31;
	localparam int IDX_W        = $clog2(MAX_ENTRIES);
	localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);

	// Fixed-point word for CORDIC vectors and angles (Q30 with headroom).
	localparam int Q_W = 34;
	typedef logic signed [Q_W-1:0] q_t;

	localparam logic [31:0]  KQ40        = 32'd1919010;
	localparam logic [33:0]  PI_Q30      = 34'd3373259426;
	localparam logic [33:0]  HALF_PI_Q30 = 34'd1686629713;
	localparam logic [30:0]  ONE_Q30     = 31'h4000_0000;
	localparam q_t           GAIN_INV    = 34'sd652032874;
	localparam logic [25:0]  DIST_MAX    = '1;

	// Configuration register indexes.
	localparam logic REG_ENTRY_COUNT   = 1'b0;
	localparam logic REG_SPHERE_RADIUS = 1'b1;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ANG_MUL,
		ST_ANG_RED,
		ST_ROT_WAIT,
		ST_RD_WAIT,
		ST_RD_LATCH,
		ST_SQA_MUL,
		ST_SQA_RND,
		ST_CC_MUL,
		ST_CC_RND,
		ST_SQB_MUL,
		ST_SQB_RND,
		ST_PB_MUL,
		ST_PB_RND,
		ST_SQRT_Y,
		ST_SQRT_Y_WAIT,
		ST_SQRT_X,
		ST_SQRT_X_WAIT,
		ST_VEC,
		ST_VEC_WAIT,
		ST_DIST_MUL,
		ST_DIST_RND
	} st_t;

	// Which angle the shared rotation is working on.
	typedef enum logic [1:0] {
		PH_COSQ,
		PH_SLAT,
		PH_COS2,
		PH_SLON
	} ph_t;

	typedef struct packed {
		logic start;
		logic vect;
		q_t   x;
		q_t   y;
		q_t   z;
	} cordic_req_t;

	typedef struct packed {
		logic done;
		q_t   x;
		q_t   y;
		q_t   z;
	} cordic_rsp_t;

	typedef struct packed {
		logic        start;
		logic [30:0] val;
	} sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] root;
	} sqrt_rsp_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic q_t atan_q30(input int i);
		q_t v;
		case (i)
			0:       v = 34'sd843314857;
			1:       v = 34'sd497837829;
			2:       v = 34'sd263043837;
			3:       v = 34'sd133525159;
			4:       v = 34'sd67021687;
			5:       v = 34'sd33543516;
			6:       v = 34'sd16775851;
			7:       v = 34'sd8388437;
			8:       v = 34'sd4194283;
			9:       v = 34'sd2097149;
			default: v = (i <= 30) ? q_t'(34'd1 << (30 - i)) : '0;
		endcase
		return v;
	endfunction

endpackage

@@ src/npgc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module npgc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/npgc_cordic.sv @@
`timescale 1ns / 1ps
// Iterative CORDIC, one micro-rotation per cycle, in rotation or vectoring mode.
// Depends on npgc_pkg for the word type, step count and arctangent table.
module npgc_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  npgc_pkg::cordic_req_t req,
	output npgc_pkg::cordic_rsp_t rsp
);
	import npgc_pkg::*;

	localparam int CW = $clog2(CORDIC_STEPS + 1);

	logic          run_q;
	logic          vect_q;
	logic [CW-1:0] cnt_q;
	q_t            x_q, y_q, z_q;
	q_t            dx, dy, at;
	logic          plus;

	// One micro-rotation; shifts of negative values floor.
	always_comb begin
		dx   = y_q >>> cnt_q;
		dy   = x_q >>> cnt_q;
		at   = atan_q30(int'(cnt_q));
		plus = vect_q ? !(y_q > 0) : (z_q >= 0);
	end

	// Control: run for the full step count, then flag the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (cnt_q == CW'(CORDIC_STEPS)) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Vector and angle registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			vect_q <= req.vect;
			x_q    <= req.x;
			y_q    <= req.y;
			z_q    <= req.z;
		end else if (run_q && cnt_q != CW'(CORDIC_STEPS)) begin
			if (plus) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.done = run_q && (cnt_q == CW'(CORDIC_STEPS));
	assign rsp.x    = x_q;
	assign rsp.y    = y_q;
	assign rsp.z    = z_q;

endmodule

@@ src/npgc_isqrt.sv @@
`timescale 1ns / 1ps
// Bit-serial integer square root of val * 2^30, one result bit per cycle.
// Depends on npgc_pkg for the request and response types.
module npgc_isqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  npgc_pkg::sqrt_req_t req,
	output npgc_pkg::sqrt_rsp_t rsp
);
	import npgc_pkg::*;

	localparam int CW = $clog2(SQRT_STEPS + 1);

	logic          run_q;
	logic [CW-1:0] cnt_q;
	logic [61:0]   rad_q;
	logic [34:0]   rem_q;
	logic [30:0]   root_q;
	logic [34:0]   rem_sh, trial;
	logic          fits;

	// Restoring step: bring down two radicand bits and try the next root bit.
	always_comb begin
		rem_sh = {rem_q[32:0], rad_q[61:60]};
		trial  = {2'b00, root_q, 2'b01};
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			if (cnt_q == CW'(SQRT_STEPS)) begin
				run_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= {1'b0, req.val, 30'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q && cnt_q != CW'(SQRT_STEPS)) begin
			rad_q <= {rad_q[59:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[29:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[29:0], 1'b0};
			end
		end
	end

	assign rsp.done = run_q && (cnt_q == CW'(SQRT_STEPS));
	assign rsp.root = root_q;

endmodule

@@ src/nearest_point_great_circle.sv @@
`timescale 1ns / 1ps
// Nearest reference point by haversine distance. A write raises no busy.
// A query holds busy while it searches n entries, and done rises in the same cycle that busy
// falls; each entry runs three CORDIC rotations, two 31-step square roots and one CORDIC
// vectoring through the shared units. One item at a time: start is taken only while busy is
// low; done pulses for one cycle and the receiver cannot hold it off.
// Reset clears the sequencer and loads entry_count 52 and sphere_radius_m 6371009; the table
// is not cleared and holds garbage until written.
module nearest_point_great_circle (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [5:0]  entry_index,
	input  logic signed [20:0] latitude,
	input  logic signed [21:0] longitude,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata,
	output logic        done,
	output logic [5:0]  nearest_index,
	output logic [25:0] distance_m
);
	import npgc_pkg::*;

	// Configuration registers.
	logic [6:0]  entry_count_q;
	logic [23:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= 7'd52;
			radius_q      <= 24'd6371009;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_COUNT:   entry_count_q <= cfg_wdata[6:0];
				REG_SPHERE_RADIUS: radius_q      <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	st_t  state_q, state_d;
	ph_t  phase_q;
	logic acc;

	assign busy = (state_q != ST_IDLE);
	assign acc  = start && !busy;

	// Reference table, latitude over longitude.
	logic             ram_we;
	logic [IDX_W-1:0] idx_q, best_i_q;
	logic [42:0]      ram_rdata;

	assign ram_we = acc && !op && (32'(entry_index) < 32'(MAX_ENTRIES));

	npgc_ram #(.WIDTH(43), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(entry_index)),
		.wdata ({latitude, longitude}),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Shared units.
	cordic_req_t cor_req;
	cordic_rsp_t cor_rsp;
	sqrt_req_t   sq_req;
	sqrt_rsp_t   sq_rsp;

	npgc_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(cor_req), .rsp(cor_rsp));
	npgc_isqrt  u_isqrt  (.clk(clk), .arst_n(arst_n), .req(sq_req), .rsp(sq_rsp));

	// Datapath registers.
	logic signed [20:0] lat1_q, lat2_q;
	logic signed [21:0] lon1_q, lon2_q;
	logic [CNT_W-1:0]   n_q;
	q_t                 cq_q, c2_q, sv_q, p_q;
	logic               neg_q;
	logic [31:0]        alat_q, b_q;
	logic [30:0]        a_q, ry_q;
	logic signed [34:0] best_c_q;
	logic [63:0]        prod_q;
	logic               done_q;
	logic [5:0]         nearest_q;
	logic [25:0]        dist_q;

	// Shared 32x32 multiplier; operands are chosen by the sequencer.
	logic [31:0] mul_a, mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Angle preparation: difference, magnitude, scaling, reduction and fold.
	logic signed [23:0] d_s;
	logic [23:0]        d_mag;
	logic [63:0]        sum_full, sum_half, sum_r30;
	logic [33:0]        ang, red, z0, m34;
	logic               fold, full;

	always_comb begin
		case (phase_q)
			PH_COSQ: d_s = {{3{lat1_q[20]}}, lat1_q};
			PH_SLAT: d_s = {{3{lat2_q[20]}}, lat2_q} - {{3{lat1_q[20]}}, lat1_q};
			PH_COS2: d_s = {{3{lat2_q[20]}}, lat2_q};
			PH_SLON: d_s = {{2{lon2_q[21]}}, lon2_q} - {{2{lon1_q[21]}}, lon1_q};
			default: d_s = '0;
		endcase
		d_mag    = d_s[23] ? 24'(-d_s) : 24'(d_s);
		full     = (phase_q == PH_COSQ) || (phase_q == PH_COS2);
		sum_full = prod_q + 64'd512;
		sum_half = prod_q + 64'd1024;
		ang      = full ? sum_full[43:10] : sum_half[44:11];
		red      = (ang >= PI_Q30) ? ang - PI_Q30 : ang;
		fold     = red > HALF_PI_Q30;
		z0       = fold ? PI_Q30 - red : red;
		sum_r30  = prod_q + 64'h2000_0000;
		m34      = sum_r30[63:30];
	end

	// Magnitudes for the signed Q30 products.
	logic [33:0] sv_mag, cq_mag, c2_mag, p_mag;

	always_comb begin
		sv_mag = sv_q[Q_W-1] ? 34'(-sv_q) : 34'(sv_q);
		cq_mag = cq_q[Q_W-1] ? 34'(-cq_q) : 34'(cq_q);
		c2_mag = c2_q[Q_W-1] ? 34'(-c2_q) : 34'(c2_q);
		p_mag  = p_q[Q_W-1]  ? 34'(-p_q)  : 34'(p_q);
	end

	// Haversine sum, clamped to [0, 1].
	logic signed [34:0] t_s, a_sum;
	logic [30:0]        a_clamp;

	always_comb begin
		t_s   = p_q[Q_W-1] ? -$signed({1'b0, m34}) : $signed({1'b0, m34});
		a_sum = $signed({3'b000, alat_q}) + t_s;
		if (a_sum < 0) begin
			a_clamp = '0;
		end else if (a_sum > $signed({4'd0, ONE_Q30})) begin
			a_clamp = ONE_Q30;
		end else begin
			a_clamp = a_sum[30:0];
		end
	end

	// Central angle of the current entry and the search bookkeeping.
	logic signed [34:0] c_s;
	logic               last, better;
	logic [31:0]        n_sel, c_pos;

	always_comb begin
		c_s    = {cor_rsp.z, 1'b0};
		last   = (32'(idx_q) + 32'd1) == 32'(n_q);
		better = (idx_q == '0) || (c_s < best_c_q);
		c_pos  = best_c_q[34] ? 32'd0 : best_c_q[31:0];
		if (entry_count_q == 7'd0) begin
			n_sel = 32'd1;
		end else if (32'(entry_count_q) > 32'(MAX_ENTRIES)) begin
			n_sel = 32'(MAX_ENTRIES);
		end else begin
			n_sel = 32'(entry_count_q);
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, multiplier operands and unit requests.
	always_comb begin
		state_d      = state_q;
		mul_a        = '0;
		mul_b        = '0;
		cor_req      = '0;
		sq_req       = '0;
		case (state_q)
			ST_IDLE: begin
				if (acc && op) state_d = ST_ANG_MUL;
			end
			ST_ANG_MUL: begin
				mul_a   = 32'(d_mag);
				mul_b   = KQ40;
				state_d = ST_ANG_RED;
			end
			ST_ANG_RED: begin
				cor_req.start = 1'b1;
				cor_req.x     = GAIN_INV;
				cor_req.z     = $signed(z0);
				state_d       = ST_ROT_WAIT;
			end
			ST_ROT_WAIT: begin
				if (cor_rsp.done) begin
					case (phase_q)
						PH_COSQ: state_d = ST_RD_WAIT;
						PH_SLAT: state_d = ST_SQA_MUL;
						PH_COS2: state_d = ST_CC_MUL;
						PH_SLON: state_d = ST_SQB_MUL;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_WAIT:  state_d = ST_RD_LATCH;
			ST_RD_LATCH: state_d = ST_ANG_MUL;
			ST_SQA_MUL: begin
				mul_a   = sv_mag[31:0];
				mul_b   = sv_mag[31:0];
				state_d = ST_SQA_RND;
			end
			ST_SQA_RND: state_d = ST_ANG_MUL;
			ST_CC_MUL: begin
				mul_a   = cq_mag[31:0];
				mul_b   = c2_mag[31:0];
				state_d = ST_CC_RND;
			end
			ST_CC_RND: state_d = ST_ANG_MUL;
			ST_SQB_MUL: begin
				mul_a   = sv_mag[31:0];
				mul_b   = sv_mag[31:0];
				state_d = ST_SQB_RND;
			end
			ST_SQB_RND: state_d = ST_PB_MUL;
			ST_PB_MUL: begin
				mul_a   = p_mag[31:0];
				mul_b   = b_q;
				state_d = ST_PB_RND;
			end
			ST_PB_RND: state_d = ST_SQRT_Y;
			ST_SQRT_Y: begin
				sq_req.start = 1'b1;
				sq_req.val   = a_q;
				state_d      = ST_SQRT_Y_WAIT;
			end
			ST_SQRT_Y_WAIT: begin
				if (sq_rsp.done) state_d = ST_SQRT_X;
			end
			ST_SQRT_X: begin
				sq_req.start = 1'b1;
				sq_req.val   = ONE_Q30 - a_q;
				state_d      = ST_SQRT_X_WAIT;
			end
			ST_SQRT_X_WAIT: begin
				if (sq_rsp.done) state_d = ST_VEC;
			end
			ST_VEC: begin
				cor_req.start = 1'b1;
				cor_req.vect  = 1'b1;
				cor_req.x     = q_t'({3'b000, sq_rsp.root});
				cor_req.y     = q_t'({3'b000, ry_q});
				state_d       = ST_VEC_WAIT;
			end
			ST_VEC_WAIT: begin
				if (cor_rsp.done) state_d = last ? ST_DIST_MUL : ST_RD_WAIT;
			end
			ST_DIST_MUL: begin
				mul_a   = c_pos;
				mul_b   = 32'(radius_q);
				state_d = ST_DIST_RND;
			end
			ST_DIST_RND: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Control registers of the walk and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COSQ;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_DIST_RND);
			case (state_q)
				ST_IDLE: begin
					phase_q <= PH_COSQ;
					idx_q   <= '0;
				end
				ST_RD_LATCH: phase_q <= PH_SLAT;
				ST_SQA_RND:  phase_q <= PH_COS2;
				ST_CC_RND:   phase_q <= PH_SLON;
				ST_VEC_WAIT: begin
					if (cor_rsp.done && !last) idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					lat1_q <= latitude;
					lon1_q <= longitude;
					n_q    <= CNT_W'(n_sel);
				end
			end
			ST_ANG_RED: neg_q <= fold;
			ST_ROT_WAIT: begin
				if (cor_rsp.done) begin
					case (phase_q)
						PH_COSQ: cq_q <= neg_q ? -cor_rsp.x : cor_rsp.x;
						PH_COS2: c2_q <= neg_q ? -cor_rsp.x : cor_rsp.x;
						default: sv_q <= cor_rsp.y;
					endcase
				end
			end
			ST_RD_LATCH: begin
				lat2_q <= ram_rdata[42:22];
				lon2_q <= ram_rdata[21:0];
			end
			ST_SQA_RND: alat_q <= m34[31:0];
			ST_CC_RND: begin
				p_q <= (cq_q[Q_W-1] ^ c2_q[Q_W-1]) ? -$signed(m34) : $signed(m34);
			end
			ST_SQB_RND: b_q <= m34[31:0];
			ST_PB_RND:  a_q <= a_clamp;
			ST_SQRT_Y_WAIT: begin
				if (sq_rsp.done) ry_q <= sq_rsp.root;
			end
			ST_VEC_WAIT: begin
				if (cor_rsp.done && better) begin
					best_c_q <= c_s;
					best_i_q <= idx_q;
				end
			end
			ST_DIST_RND: begin
				nearest_q <= 6'(best_i_q);
				dist_q    <= (m34 > 34'(DIST_MAX)) ? DIST_MAX : m34[25:0];
			end
			default: ;
		endcase
	end

	assign done          = done_q;
	assign nearest_index = nearest_q;
	assign distance_m    = dist_q;

	// A result only follows the final rounding step.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_DIST_RND))
		else $error("result strobe without a finished query");

	// A query transfer starts the walk; a table write does not.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op) |=> busy)
		else $error("query transfer did not start the search");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !op) |=> !busy)
		else $error("table write left the block busy");

	// The walk never leaves the searched range.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (32'(idx_q) < 32'(n_q)))
		else $error("entry index beyond entry count");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for nearest_point_great_circle: directed table, then random phases.
// Depends on npgc_pkg for the register indexes and the CORDIC step count, and on the block's RTL; needs nothing else.
module tb;
	import npgc_pkg::*;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam int   STALL_LIMIT = 60000;
	localparam int   SETTLE_CYCLES = 16;
	localparam longint PI_L      = 64'sd3373259426;
	localparam longint HALF_PI_L = 64'sd1686629713;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        op;
		logic [5:0]  slot;
		int          lat;
		int          lon;
		int          want_idx;
	} stim_row_t;

	typedef struct {
		logic [5:0]  idx;
		logic [25:0] dist_m;
	} nearest_t;

	logic        clk, arst_n;
	logic        start, busy, op, done;
	logic [5:0]  entry_index, nearest_index;
	logic signed [20:0] latitude;
	logic signed [21:0] longitude;
	logic        cfg_we, cfg_index;
	logic [23:0] cfg_wdata;
	logic [25:0] distance_m;

	nearest_point_great_circle DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.entry_index(entry_index), .latitude(latitude), .longitude(longitude),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done), .nearest_index(nearest_index), .distance_m(distance_m)
	);

	// Predictor state: table, written flags and the two registers.
	longint    arctan_tbl[CORDIC_STEPS];
	longint    tbl_lat[64], tbl_lon[64];
	bit        tbl_written[64];
	longint    search_count, radius_m;
	nearest_t  pending_q[$];
	int        errors, idle_cycles;
	bit        sender_idles;
	stim_row_t dir_rows[$];

	initial begin
		clk = 1'b0;
	end
	always #6 clk = ~clk;

	function automatic void build_arctan();
		longint unsigned acc, term;
		int e;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (i == 0) begin
				arctan_tbl[i] = 843314857;
			end else begin
				acc = 0;
				for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
					e = 62 - i * (2 * k + 1);
					term = (64'd1 << e) / longint'(2 * k + 1);
					if (k & 1)
						acc -= term;
					else
						acc += term;
				end
				arctan_tbl[i] = longint'((acc + (64'd1 << 31)) >> 32);
			end
		end
	endfunction

	// Q30 product, rounded half away from zero.
	function automatic longint mul_q30(longint a, longint b);
		longint unsigned ua, ub;
		longint m;
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		m = longint'((ua * ub + (64'd1 << 29)) >> 30);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic longint floor_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(root);
	endfunction

	// Rotation mode: returns cos in c and sin in s for an angle in [0, pi/2].
	function automatic void rotate(longint z, output longint c, output longint s);
		longint x, y, dx, dy;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_tbl[i];
			end else begin
				x += dx; y -= dy; z += arctan_tbl[i];
			end
		end
		c = x;
		s = y;
	endfunction

	function automatic longint half_sin_sq(longint units);
		longint h, c, s;
		h = longint'(((units < 0 ? -units : units) * 1919010 + 1024) >> 11);
		h = h % PI_L;
		if (h > HALF_PI_L)
			h = PI_L - h;
		rotate(h, c, s);
		return mul_q30(s, s);
	endfunction

	function automatic longint lat_cos(longint units);
		longint ang, c, s;
		ang = longint'(((units < 0 ? -units : units) * 1919010 + 512) >> 10);
		ang = ang % PI_L;
		if (ang > HALF_PI_L) begin
			rotate(PI_L - ang, c, s);
			return -c;
		end
		rotate(ang, c, s);
		return c;
	endfunction

	// Haversine central angle in Q30 radians.
	function automatic longint arc_angle(longint la1, longint lo1, longint la2, longint lo2);
		longint a, x, y, z, dx, dy;
		a = half_sin_sq(la2 - la1) +
			mul_q30(mul_q30(lat_cos(la1), lat_cos(la2)), half_sin_sq(lo2 - lo1));
		if (a < 0)
			a = 0;
		if (a > (64'd1 << 30))
			a = 64'd1 << 30;
		y = floor_sqrt(a << 30);
		x = floor_sqrt(((64'd1 << 30) - a) << 30);
		z = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx; y -= dy; z += arctan_tbl[i];
			end else begin
				x -= dx; y += dy; z -= arctan_tbl[i];
			end
		end
		return 2 * z;
	endfunction

	function automatic nearest_t find_nearest(longint la, longint lo);
		nearest_t r;
		longint n, c, best_c, d;
		n = search_count;
		if (n < 1)
			n = 1;
		if (n > 64)
			n = 64;
		best_c = 0;
		r.idx = '0;
		for (int i = 0; i < n; i++) begin
			c = arc_angle(la, lo, tbl_lat[i], tbl_lon[i]);
			if (i == 0 || c < best_c) begin
				best_c = c;
				r.idx = i[5:0];
			end
		end
		if (best_c < 0)
			best_c = 0;
		d = (radius_m * best_c + (64'd1 << 29)) >>> 30;
		r.dist_m = (d > 67108863) ? 26'h3FF_FFFF : d[25:0];
		return r;
	endfunction

	function automatic int slots_searched();
		return int'((search_count < 1) ? 1 : (search_count > 64) ? 64 : search_count);
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Result monitor: every done pulse is one transfer out.
	always @(posedge clk) begin
		nearest_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result, nearest_index", nearest_index, -1);
			end else begin
				e = pending_q.pop_front();
				if (nearest_index !== e.idx)
					report_mismatch("nearest_index", nearest_index, e.idx);
				if (distance_m !== e.dist_m)
					report_mismatch("distance_m", distance_m, e.dist_m);
			end
		end
	end

	// Watchdog: counts cycles with no transfer in either direction.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("nearest_point_great_circle test failed");
			$finish;
		end
	end

	// Drive one item and hold it until the block takes it, then predict.
	task automatic send_item(logic o, logic [5:0] slot, int la, int lo, int want_idx);
		nearest_t r;
		if (sender_idles && $urandom_range(99) < 33) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start       <= 1'b1;
		op          <= o;
		entry_index <= slot;
		latitude    <= la[20:0];
		longitude   <= lo[21:0];
		do @(posedge clk); while (busy);
		if (o == OP_WRITE) begin
			tbl_lat[slot] = longint'(latitude);
			tbl_lon[slot] = longint'(longitude);
			tbl_written[slot] = 1'b1;
		end else begin
			r = find_nearest(longint'(latitude), longint'(longitude));
			if (want_idx >= 0)
				r.idx = want_idx[5:0];
			pending_q.push_back(r);
		end
	endtask

	// Register write, only once the block has drained and settled.
	task automatic write_reg(logic idx, logic [23:0] val);
		start <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0 || busy);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENTRY_COUNT)
			search_count = val & 24'h7F;
		else
			radius_m = val;
	endtask

	// A register row keeps its full write value in the latitude column.
	function automatic void add_row(row_kind_t k, logic o, int slot, int la, int lo, int w);
		stim_row_t r;
		r.kind = k; r.op = o; r.slot = slot[5:0]; r.lon = lo; r.want_idx = w;
		r.lat = (k == ROW_CFG) ? slot : la;
		dir_rows.push_back(r);
	endfunction

	function automatic int rand_lat();
		case ($urandom_range(3))
			0:       return $urandom_range(2097151) - 1048576;
			1:       return ($urandom_range(1)) ? 900000 : -900000;
			default: return $urandom_range(1800000) - 900000;
		endcase
	endfunction

	function automatic int rand_lon();
		case ($urandom_range(3))
			0:       return $urandom_range(4194303) - 2097152;
			1:       return ($urandom_range(1)) ? 1800000 - $urandom_range(50) :
				$urandom_range(50) - 1800000;
			default: return $urandom_range(3600000) - 1800000;
		endcase
	endfunction

	initial begin
		int phase_counts[7];
		int free_slot, pick;
		phase_counts = '{5, 52, 2, 64, 8, 127, 3};
		arst_n = 1'b0; start = 1'b0; op = OP_WRITE; entry_index = '0;
		latitude = '0; longitude = '0; cfg_we = 1'b0; cfg_index = REG_ENTRY_COUNT;
		cfg_wdata = '0; errors = 0; idle_cycles = 0; sender_idles = 1'b1;
		search_count = 52; radius_m = 6371009;
		build_arctan();
		for (int i = 0; i < 64; i++) begin
			tbl_lat[i] = 0; tbl_lon[i] = 0; tbl_written[i] = 1'b0;
		end

		// Directed table: count zero, all-ones fields, antimeridian, ties, extreme radii.
		add_row(ROW_CFG,  REG_ENTRY_COUNT,   0, 0, 0, -1);
		add_row(ROW_ITEM, OP_WRITE,  0, 0, 0, -1);
		add_row(ROW_ITEM, OP_QUERY,  5, 0, 0, 0);
		add_row(ROW_ITEM, OP_WRITE,  0, 900000, 1800000, -1);
		add_row(ROW_ITEM, OP_QUERY,  0, -900000, -1800000, 0);
		add_row(ROW_ITEM, OP_WRITE, 63, -1048576, -2097152, -1);
		add_row(ROW_ITEM, OP_WRITE,  0, 1048575, 2097151, -1);
		add_row(ROW_ITEM, OP_QUERY, 63, -1048576, -2097152, 0);
		add_row(ROW_ITEM, OP_QUERY,  0, 0, 1799999, 0);
		add_row(ROW_CFG,  REG_ENTRY_COUNT,   3, 0, 0, -1);
		add_row(ROW_CFG,  REG_SPHERE_RADIUS, 1, 0, 0, -1);
		add_row(ROW_ITEM, OP_WRITE,  1, 100000, -1799999, -1);
		add_row(ROW_ITEM, OP_WRITE,  2, 100000, -1799999, -1);
		add_row(ROW_ITEM, OP_QUERY, 42, 100000, 1800000, -1);
		add_row(ROW_ITEM, OP_QUERY,  0, 100000, -1799999, -1);
		add_row(ROW_CFG,  REG_ENTRY_COUNT,   2, 0, 0, -1);
		add_row(ROW_CFG,  REG_SPHERE_RADIUS, 16777215, 0, 0, -1);
		add_row(ROW_ITEM, OP_QUERY,  0, -900000, 0, -1);
		add_row(ROW_ITEM, OP_QUERY,  0, 900000, 0, -1);
		add_row(ROW_ITEM, OP_WRITE,  1, -900000, 900000, -1);
		add_row(ROW_ITEM, OP_QUERY,  0, -900000, -900000, -1);
		add_row(ROW_ITEM, OP_QUERY,  0, 0, 0, -1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].op, 24'(dir_rows[i].lat));
			else
				send_item(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].lat,
					dir_rows[i].lon, dir_rows[i].want_idx);
		end

		// Random phases; a query over an unwritten slot becomes a fill write instead.
		for (int p = 0; p < 7; p++) begin
			write_reg(REG_ENTRY_COUNT, 24'(phase_counts[p]));
			write_reg(REG_SPHERE_RADIUS, (p == 2) ? 24'd6371009 : 24'($urandom_range(1, 16777215)));
			sender_idles = (p != 2);
			for (int n = 0; n < 20; n++) begin
				free_slot = -1;
				for (int s = slots_searched() - 1; s >= 0; s--)
					if (!tbl_written[s])
						free_slot = s;
				if (free_slot >= 0) begin
					send_item(OP_WRITE, free_slot[5:0], rand_lat(), rand_lon(), -1);
				end else if ($urandom_range(1)) begin
					send_item(OP_QUERY, 6'($urandom), rand_lat(), rand_lon(), -1);
				end else begin
					pick = (phase_counts[p] > 10 && $urandom_range(1)) ? $urandom_range(63) :
						$urandom_range(slots_searched() - 1);
					send_item(OP_WRITE, pick[5:0], rand_lat(), rand_lon(), -1);
				end
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("nearest_point_great_circle test passed");
		else
			$display("nearest_point_great_circle test failed");
		$finish;
	end
endmodule
